### src/ppp_pkg.sv
// Shared constants, types and register codes for the perspective point projection block.
`default_nettype none

package ppp_pkg;

   localparam int COORD_WIDTH  = 24;
   localparam int OUT_WIDTH    = 32;
   localparam int COEF_WIDTH   = 21;
   localparam int COEF_FRAC    = 18;
   localparam int FOCAL_WIDTH  = 24;
   localparam int FOCAL_FRAC   = 16;
   localparam int STATUS_WIDTH = 2;

   localparam int ROW_WIDTH       = 3 * COEF_WIDTH;
   localparam int OFFSET_XY_WIDTH = 2 * COORD_WIDTH;
   localparam int CSR_DATA_WIDTH  =
      (ROW_WIDTH > OFFSET_XY_WIDTH) ? ROW_WIDTH : OFFSET_XY_WIDTH;
   localparam int CSR_INDEX_WIDTH = 3;

   // Exact eye-space accumulation keeps COEF_FRAC extra fraction bits.
   localparam int PROD_WIDTH = COORD_WIDTH + COEF_WIDTH;
   localparam int ACC_WIDTH  = PROD_WIDTH + 2;
   localparam int EYE_WIDTH  = ACC_WIDTH - COEF_FRAC;

   // Scaled numerator, divisor magnitude and the divider working width.
   localparam int NUM_WIDTH = EYE_WIDTH + FOCAL_WIDTH + 1;
   localparam int DIV_WIDTH = EYE_WIDTH;
   localparam int QUO_WIDTH = OUT_WIDTH + 1;
   localparam int REM_WIDTH =
      ((NUM_WIDTH > DIV_WIDTH + OUT_WIDTH) ? NUM_WIDTH : DIV_WIDTH + OUT_WIDTH) + 1;

   localparam int FRONT_STAGES = 4;
   localparam int DIV_STAGES   = QUO_WIDTH;
   localparam int LATENCY      = FRONT_STAGES + DIV_STAGES + 1;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_VIEW_ROW_X    = 3'd0,
      CSR_VIEW_ROW_Y    = 3'd1,
      CSR_VIEW_ROW_Z    = 3'd2,
      CSR_OFFSET_XY     = 3'd3,
      CSR_OFFSET_DEPTH  = 3'd4,
      CSR_FOCAL_SCALE   = 3'd5
   } csr_index_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_OK         = 2'd0,
      STATUS_DEPTH_ZERO = 2'd1,
      STATUS_SATURATED  = 2'd2
   } status_type;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   typedef struct packed {
      logic [2:0][ROW_WIDTH-1:0]    rows;
      logic [OFFSET_XY_WIDTH-1:0]   offset_xy;
      logic [COORD_WIDTH-1:0]       offset_depth;
      logic [FOCAL_WIDTH-1:0]       focal;
   } view_cfg_type;

   typedef struct packed {
      logic signed [EYE_WIDTH-1:0] x;
      logic signed [EYE_WIDTH-1:0] y;
      logic signed [EYE_WIDTH-1:0] z;
   } eye_type;

   typedef struct packed {
      logic [REM_WIDTH-1:0] rem;
      logic [DIV_WIDTH-1:0] div;
      logic [QUO_WIDTH-1:0] quo;
      logic                 neg;
      logic                 depth_zero;
   } div_operand_type;

endpackage

`default_nettype wire

### src/ppp_req_if.sv
// Request channel carrying one world-space point.
`default_nettype none

interface ppp_req_if;
   import ppp_pkg::*;

   logic      valid;
   logic      ready;
   coord_type point_x;
   coord_type point_y;
   coord_type point_z;

   modport source (output valid, output point_x, output point_y, output point_z,
                   input ready);
   modport sink   (input valid, input point_x, input point_y, input point_z,
                   output ready);
endinterface

`default_nettype wire

### src/ppp_rsp_if.sv
// Response channel carrying one projected point and its status.
`default_nettype none

interface ppp_rsp_if;
   import ppp_pkg::*;

   logic                        valid;
   logic                        ready;
   logic signed [OUT_WIDTH-1:0] proj_x;
   logic signed [OUT_WIDTH-1:0] proj_y;
   logic [STATUS_WIDTH-1:0]     proj_status;

   modport source (output valid, output proj_x, output proj_y, output proj_status,
                   input ready);
   modport sink   (input valid, input proj_x, input proj_y, input proj_status,
                   output ready);
endinterface

`default_nettype wire

### src/ppp_transform.sv
// Two-stage view transform: nine coefficient products, then row sums with offset and rounding.
`default_nettype none

module ppp_transform (
   input  logic                                       clock,
   input  logic                                       advance,
   input  logic [2:0][ppp_pkg::COORD_WIDTH-1:0]       point,
   input  ppp_pkg::view_cfg_type                      cfg,
   output ppp_pkg::eye_type                           eye
);
   import ppp_pkg::*;

   localparam logic signed [ACC_WIDTH-1:0] ROUND_HALF = ACC_WIDTH'(1) <<< (COEF_FRAC - 1);

   logic signed [PROD_WIDTH-1:0] prod_ff [3][3];
   logic signed [PROD_WIDTH-1:0] prod_in [3][3];
   eye_type                      eye_ff;
   eye_type                      eye_in;
   logic [COORD_WIDTH-1:0]       offset [3];
   logic signed [ACC_WIDTH-1:0]  acc [3];

   always_comb begin
      logic signed [PROD_WIDTH-1:0] coord_ext;
      logic signed [PROD_WIDTH-1:0] coef_ext;
      logic [COEF_WIDTH-1:0]        coef_raw;
      for (int r = 0; r < 3; r++) begin
         for (int k = 0; k < 3; k++) begin
            coef_raw  = cfg.rows[r][k*COEF_WIDTH +: COEF_WIDTH];
            coord_ext = {{COEF_WIDTH{point[k][COORD_WIDTH-1]}}, point[k]};
            coef_ext  = {{COORD_WIDTH{coef_raw[COEF_WIDTH-1]}}, coef_raw};
            prod_in[r][k] = coord_ext * coef_ext;
         end
      end
   end

   assign offset[0] = cfg.offset_xy[COORD_WIDTH-1:0];
   assign offset[1] = cfg.offset_xy[2*COORD_WIDTH-1:COORD_WIDTH];
   assign offset[2] = cfg.offset_depth;

   // The rounded eye coordinate is the floor of the biased sum, i.e. its upper bits.
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         acc[r] = {{2{prod_ff[r][0][PROD_WIDTH-1]}}, prod_ff[r][0]}
                + {{2{prod_ff[r][1][PROD_WIDTH-1]}}, prod_ff[r][1]}
                + {{2{prod_ff[r][2][PROD_WIDTH-1]}}, prod_ff[r][2]}
                + {{(ACC_WIDTH-COORD_WIDTH-COEF_FRAC){offset[r][COORD_WIDTH-1]}},
                   offset[r], {COEF_FRAC{1'b0}}}
                + ROUND_HALF;
      end
      eye_in.x = acc[0][ACC_WIDTH-1:COEF_FRAC];
      eye_in.y = acc[1][ACC_WIDTH-1:COEF_FRAC];
      eye_in.z = acc[2][ACC_WIDTH-1:COEF_FRAC];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
         eye_ff  <= eye_in;
      end
   end

   assign eye = eye_ff;

endmodule

`default_nettype wire

### src/ppp_scale.sv
// Two-stage focal scaling and sign split that prepares magnitudes for the dividers.
`default_nettype none

module ppp_scale (
   input  logic                               clock,
   input  logic                               advance,
   input  ppp_pkg::eye_type                   eye,
   input  logic [ppp_pkg::FOCAL_WIDTH-1:0]    focal,
   output ppp_pkg::div_operand_type           op_x,
   output ppp_pkg::div_operand_type           op_y
);
   import ppp_pkg::*;

   logic signed [NUM_WIDTH-1:0] num_x_ff;
   logic signed [NUM_WIDTH-1:0] num_x_in;
   logic signed [NUM_WIDTH-1:0] num_y_ff;
   logic signed [NUM_WIDTH-1:0] num_y_in;
   logic signed [EYE_WIDTH-1:0] depth_ff;
   logic [DIV_WIDTH-1:0]        depth_mag;
   div_operand_type             op_x_ff;
   div_operand_type             op_x_in;
   div_operand_type             op_y_ff;
   div_operand_type             op_y_in;

   function automatic div_operand_type make_operand(
      input logic signed [NUM_WIDTH-1:0] num,
      input logic                        depth_neg,
      input logic [DIV_WIDTH-1:0]        dmag,
      input logic                        zero
   );
      div_operand_type     op;
      logic [NUM_WIDTH-1:0] nmag;
      nmag          = num[NUM_WIDTH-1] ? -num : num;
      op.rem        = {{(REM_WIDTH-NUM_WIDTH){1'b0}}, nmag};
      op.div        = dmag;
      op.quo        = '0;
      op.neg        = num[NUM_WIDTH-1] ^ depth_neg;
      op.depth_zero = zero;
      return op;
   endfunction

   always_comb begin
      logic signed [NUM_WIDTH-1:0] ex_ext;
      logic signed [NUM_WIDTH-1:0] ey_ext;
      logic signed [NUM_WIDTH-1:0] f_ext;
      ex_ext   = {{(FOCAL_WIDTH+1){eye.x[EYE_WIDTH-1]}}, eye.x};
      ey_ext   = {{(FOCAL_WIDTH+1){eye.y[EYE_WIDTH-1]}}, eye.y};
      f_ext    = {{(EYE_WIDTH+1){1'b0}}, focal};
      num_x_in = ex_ext * f_ext;
      num_y_in = ey_ext * f_ext;
   end

   assign depth_mag = depth_ff[EYE_WIDTH-1] ? -depth_ff : depth_ff;
   assign op_x_in   = make_operand(num_x_ff, depth_ff[EYE_WIDTH-1], depth_mag, depth_ff == '0);
   assign op_y_in   = make_operand(num_y_ff, depth_ff[EYE_WIDTH-1], depth_mag, depth_ff == '0);

   always_ff @(posedge clock) begin
      if (advance) begin
         num_x_ff <= num_x_in;
         num_y_ff <= num_y_in;
         depth_ff <= eye.z;
         op_x_ff  <= op_x_in;
         op_y_ff  <= op_y_in;
      end
   end

   assign op_x = op_x_ff;
   assign op_y = op_y_ff;

endmodule

`default_nettype wire

### src/ppp_divider.sv
// Pipelined restoring divider, one quotient bit per stage; the top bit flags an oversized quotient.
`default_nettype none

module ppp_divider (
   input  logic                       clock,
   input  logic                       advance,
   input  ppp_pkg::div_operand_type   operand,
   output ppp_pkg::div_operand_type   result
);
   import ppp_pkg::*;

   div_operand_type stage_ff [DIV_STAGES];
   div_operand_type stage_in [DIV_STAGES];

   function automatic div_operand_type div_step(
      input div_operand_type cur,
      input int unsigned     bit_pos
   );
      div_operand_type      nxt;
      logic [REM_WIDTH-1:0] trial;
      nxt   = cur;
      trial = REM_WIDTH'(cur.div) << bit_pos;
      if (cur.rem >= trial) begin
         nxt.rem = cur.rem - trial;
         nxt.quo = cur.quo | (QUO_WIDTH'(1) << bit_pos);
      end
      return nxt;
   endfunction

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_step
      if (k == 0) begin : g_first
         assign stage_in[k] = div_step(operand, DIV_STAGES - 1 - k);
      end else begin : g_next
         assign stage_in[k] = div_step(stage_ff[k-1], DIV_STAGES - 1 - k);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < DIV_STAGES; k++) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   assign result = stage_ff[DIV_STAGES-1];

endmodule

`default_nettype wire

### src/ppp_output.sv
// Final stage: applies the quotient sign, clamps to the output range and sets the status.
`default_nettype none

module ppp_output (
   input  logic                                clock,
   input  logic                                advance,
   input  ppp_pkg::div_operand_type            res_x,
   input  ppp_pkg::div_operand_type            res_y,
   output logic signed [ppp_pkg::OUT_WIDTH-1:0] proj_x,
   output logic signed [ppp_pkg::OUT_WIDTH-1:0] proj_y,
   output ppp_pkg::status_type                 proj_status
);
   import ppp_pkg::*;

   localparam logic [QUO_WIDTH-1:0] LIMIT_MAG = QUO_WIDTH'(1) << (OUT_WIDTH - 1);
   localparam logic [OUT_WIDTH-1:0] OUT_MAX   = {1'b0, {(OUT_WIDTH-1){1'b1}}};
   localparam logic [OUT_WIDTH-1:0] OUT_MIN   = {1'b1, {(OUT_WIDTH-1){1'b0}}};

   logic signed [OUT_WIDTH-1:0] proj_x_ff;
   logic signed [OUT_WIDTH-1:0] proj_x_in;
   logic signed [OUT_WIDTH-1:0] proj_y_ff;
   logic signed [OUT_WIDTH-1:0] proj_y_in;
   status_type                  status_ff;
   status_type                  status_in;
   logic [OUT_WIDTH:0]          clamp_x;
   logic [OUT_WIDTH:0]          clamp_y;

   // Returns the saturation flag above the signed result.
   function automatic logic [OUT_WIDTH:0] clamp(input div_operand_type r);
      logic [OUT_WIDTH-1:0] mag;
      logic [OUT_WIDTH:0]   res;
      mag = r.quo[OUT_WIDTH-1:0];
      priority if (!r.neg && r.quo >= LIMIT_MAG) begin
         res = {1'b1, OUT_MAX};
      end else if (r.neg && r.quo > LIMIT_MAG) begin
         res = {1'b1, OUT_MIN};
      end else if (r.neg) begin
         res = {1'b0, -mag};
      end else begin
         res = {1'b0, mag};
      end
      return res;
   endfunction

   assign clamp_x = clamp(res_x);
   assign clamp_y = clamp(res_y);

   always_comb begin
      priority if (res_x.depth_zero) begin
         proj_x_in = '0;
         proj_y_in = '0;
         status_in = STATUS_DEPTH_ZERO;
      end else begin
         proj_x_in = clamp_x[OUT_WIDTH-1:0];
         proj_y_in = clamp_y[OUT_WIDTH-1:0];
         status_in = (clamp_x[OUT_WIDTH] || clamp_y[OUT_WIDTH]) ? STATUS_SATURATED : STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         proj_x_ff <= proj_x_in;
         proj_y_ff <= proj_y_in;
         status_ff <= status_in;
      end
   end

   assign proj_x      = proj_x_ff;
   assign proj_y      = proj_y_ff;
   assign proj_status = status_ff;

endmodule

`default_nettype wire

### src/perspective_point_projection.sv
// Top level of the perspective point projection pipeline with its configuration registers.
`default_nettype none

// Each request carries one world-space point in signed Q16.8; it is rotated by the
// configured 3x3 view matrix (Q3.18), offset into eye space, scaled by the focal factor
// and divided by the eye depth to give a signed Q16.16 projected point. The pipeline
// accepts one request per clock while results are taken, passing it through two stages
// of view transform, two of focal scaling and sign split, 33 restoring-divider stages
// (one quotient bit each) and a clamp stage. When a finished result is not taken, the
// whole pipeline holds and no new request is accepted until the response is consumed.
// A zero eye depth returns zeros with status 1; a quotient outside the output range is
// clamped and reported with status 2. The user must ensure configuration registers are
// written through the csr port while no request is in flight; the block never checks.

module perspective_point_projection (
   input  logic                                  clock,
   input  logic                                  reset,
   ppp_req_if.sink                               req_channel,
   ppp_rsp_if.source                             rsp_channel,
   input  logic                                  csr_wr_en,
   input  logic [ppp_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [ppp_pkg::CSR_DATA_WIDTH-1:0]    csr_data
);
   import ppp_pkg::*;

   localparam logic [ROW_WIDTH-1:0]   COEF_ONE  = ROW_WIDTH'(1) << COEF_FRAC;
   localparam logic [FOCAL_WIDTH-1:0] FOCAL_ONE = FOCAL_WIDTH'(1) << FOCAL_FRAC;

   logic [2:0][ROW_WIDTH-1:0]  rows_ff;
   logic [OFFSET_XY_WIDTH-1:0] offset_xy_ff;
   logic [COORD_WIDTH-1:0]     offset_depth_ff;
   logic [FOCAL_WIDTH-1:0]     focal_ff;
   view_cfg_type               cfg;

   logic [LATENCY-1:0]         vld_ff;
   logic [LATENCY-1:0]         vld_in;
   logic                       advance;

   logic [2:0][COORD_WIDTH-1:0] point;
   eye_type                     eye;
   div_operand_type             op_x;
   div_operand_type             op_y;
   div_operand_type             res_x;
   div_operand_type             res_y;
   status_type                  status;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff[0]      <= COEF_ONE;
         rows_ff[1]      <= COEF_ONE << COEF_WIDTH;
         rows_ff[2]      <= COEF_ONE << (2 * COEF_WIDTH);
         offset_xy_ff    <= '0;
         offset_depth_ff <= '0;
         focal_ff        <= FOCAL_ONE;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_VIEW_ROW_X:   rows_ff[0]      <= csr_data[ROW_WIDTH-1:0];
            CSR_VIEW_ROW_Y:   rows_ff[1]      <= csr_data[ROW_WIDTH-1:0];
            CSR_VIEW_ROW_Z:   rows_ff[2]      <= csr_data[ROW_WIDTH-1:0];
            CSR_OFFSET_XY:    offset_xy_ff    <= csr_data[OFFSET_XY_WIDTH-1:0];
            CSR_OFFSET_DEPTH: offset_depth_ff <= csr_data[COORD_WIDTH-1:0];
            CSR_FOCAL_SCALE:  focal_ff        <= csr_data[FOCAL_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   assign cfg.rows         = rows_ff;
   assign cfg.offset_xy    = offset_xy_ff;
   assign cfg.offset_depth = offset_depth_ff;
   assign cfg.focal        = focal_ff;

   // The pipeline moves as one; it freezes only while the last stage holds an untaken result.
   assign advance = !vld_ff[LATENCY-1] || rsp_channel.ready;
   assign vld_in  = {vld_ff[LATENCY-2:0], req_channel.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   assign req_channel.ready = advance;
   assign point = {req_channel.point_z, req_channel.point_y, req_channel.point_x};

   ppp_transform u_transform (
      .clock   (clock),
      .advance (advance),
      .point   (point),
      .cfg     (cfg),
      .eye     (eye)
   );

   ppp_scale u_scale (
      .clock   (clock),
      .advance (advance),
      .eye     (eye),
      .focal   (cfg.focal),
      .op_x    (op_x),
      .op_y    (op_y)
   );

   ppp_divider u_divider_x (
      .clock   (clock),
      .advance (advance),
      .operand (op_x),
      .result  (res_x)
   );

   ppp_divider u_divider_y (
      .clock   (clock),
      .advance (advance),
      .operand (op_y),
      .result  (res_y)
   );

   ppp_output u_output (
      .clock       (clock),
      .advance     (advance),
      .res_x       (res_x),
      .res_y       (res_y),
      .proj_x      (rsp_channel.proj_x),
      .proj_y      (rsp_channel.proj_y),
      .proj_status (status)
   );

   assign rsp_channel.proj_status = status;
   assign rsp_channel.valid       = vld_ff[LATENCY-1];

   // A held response must keep new requests out, or an item would be overwritten.
   assert property (@(posedge clock) disable iff (reset)
      rsp_channel.valid && !rsp_channel.ready |-> !req_channel.ready)
      else $error("request accepted while the response stage is stalled");

   // A zero eye depth always reports a zero projected point.
   assert property (@(posedge clock) disable iff (reset)
      rsp_channel.valid && rsp_channel.proj_status == STATUS_DEPTH_ZERO
         |-> rsp_channel.proj_x == '0 && rsp_channel.proj_y == '0)
      else $error("depth-zero response with nonzero coordinates");

   // Once the pipeline has drained, nothing comes out without a prior request.
   assert property (@(posedge clock) disable iff (reset)
      advance && vld_ff == '0 && !req_channel.valid |=> vld_ff == '0)
      else $error("valid bit appeared in an empty pipeline");

endmodule

`default_nettype wire

### sim/ppp_projection_checker.sv
// Checker that predicts each projected point from the observed requests and compares results.
module ppp_projection_checker (
   input  logic                                clock,
   input  logic                                reset,
   ppp_req_if                                  req_channel,
   ppp_rsp_if                                  rsp_channel,
   input  logic                                csr_wr_en,
   input  logic [ppp_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [ppp_pkg::CSR_DATA_WIDTH-1:0]  csr_data,
   output int                                  points_in_flight,
   output int                                  failure_count,
   output int                                  checked_count,
   output int                                  depth_zero_count,
   output int                                  saturated_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import ppp_pkg::*;

   localparam longint OUT_MAX = (longint'(1) <<< (OUT_WIDTH - 1)) - 1;
   localparam longint OUT_MIN = -OUT_MAX - 1;

   typedef struct packed {
      logic signed [OUT_WIDTH-1:0] x;
      logic signed [OUT_WIDTH-1:0] y;
      status_type                  status;
   } projection_type;

   logic [ROW_WIDTH-1:0]       view_rows [3];
   logic [OFFSET_XY_WIDTH-1:0] eye_offset_xy;
   logic [COORD_WIDTH-1:0]     eye_offset_depth;
   logic [FOCAL_WIDTH-1:0]     focal_scale;

   projection_type expected_points [$];

   // One eye-space axis: exact sum with the coefficient fraction bits kept, then
   // rounded half up back to the coordinate format.
   function automatic longint eye_axis(input logic [ROW_WIDTH-1:0] row, input coord_type offset,
                                       input coord_type px, input coord_type py,
                                       input coord_type pz);
      logic signed [COEF_WIDTH-1:0] cx;
      logic signed [COEF_WIDTH-1:0] cy;
      logic signed [COEF_WIDTH-1:0] cz;
      longint                       acc;
      cx = row[0 +: COEF_WIDTH];
      cy = row[COEF_WIDTH +: COEF_WIDTH];
      cz = row[2*COEF_WIDTH +: COEF_WIDTH];
      acc = longint'(offset) * (longint'(1) <<< COEF_FRAC)
          + longint'(px) * longint'(cx) + longint'(py) * longint'(cy)
          + longint'(pz) * longint'(cz);
      return (acc + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
   endfunction

   function automatic logic signed [OUT_WIDTH-1:0] clamp_quotient(input longint q);
      if (q > OUT_MAX) return OUT_MAX[OUT_WIDTH-1:0];
      if (q < OUT_MIN) return OUT_MIN[OUT_WIDTH-1:0];
      return q[OUT_WIDTH-1:0];
   endfunction

   function automatic projection_type project_point(input coord_type px, input coord_type py,
                                                    input coord_type pz);
      projection_type result;
      longint         ex;
      longint         ey;
      longint         ez;
      longint         qx;
      longint         qy;
      ex = eye_axis(view_rows[0], coord_type'(eye_offset_xy[0 +: COORD_WIDTH]), px, py, pz);
      ey = eye_axis(view_rows[1], coord_type'(eye_offset_xy[COORD_WIDTH +: COORD_WIDTH]),
                    px, py, pz);
      ez = eye_axis(view_rows[2], coord_type'(eye_offset_depth), px, py, pz);
      if (ez == 0) begin
         result.x = '0;
         result.y = '0;
         result.status = STATUS_DEPTH_ZERO;
      end else begin
         // SystemVerilog division of signed operands truncates toward zero.
         qx = (ex * longint'(focal_scale)) / ez;
         qy = (ey * longint'(focal_scale)) / ez;
         result.x = clamp_quotient(qx);
         result.y = clamp_quotient(qy);
         if (qx > OUT_MAX || qx < OUT_MIN || qy > OUT_MAX || qy < OUT_MIN)
            result.status = STATUS_SATURATED;
         else
            result.status = STATUS_OK;
      end
      return result;
   endfunction

   always @(posedge clock) begin
      projection_type want;
      if (reset) begin
         view_rows[0] = ROW_WIDTH'(1) << COEF_FRAC;
         view_rows[1] = ROW_WIDTH'(1) << (COEF_FRAC + COEF_WIDTH);
         view_rows[2] = ROW_WIDTH'(1) << (COEF_FRAC + 2 * COEF_WIDTH);
         eye_offset_xy = '0;
         eye_offset_depth = '0;
         focal_scale = FOCAL_WIDTH'(1) << FOCAL_FRAC;
         expected_points.delete();
         failure_count = 0;
         checked_count = 0;
         depth_zero_count = 0;
         saturated_count = 0;
      end else begin
         // Results first, so a request taken in the same cycle is never matched against itself.
         if (rsp_channel.valid && rsp_channel.ready) begin
            if (expected_points.size() == 0) begin
               if (failure_count < 10)
                  $display("%0t: result with no request outstanding: x=%0d y=%0d status=%0d",
                           $realtime, rsp_channel.proj_x, rsp_channel.proj_y,
                           rsp_channel.proj_status);
               failure_count++;
            end else begin
               want = expected_points.pop_front();
               if (rsp_channel.proj_x !== want.x || rsp_channel.proj_y !== want.y ||
                   rsp_channel.proj_status !== want.status) begin
                  if (failure_count < 10)
                     $display("%0t: point %0d exp x=%0d y=%0d st=%0d, got x=%0d y=%0d st=%0d",
                              $realtime, checked_count, want.x, want.y, want.status,
                              rsp_channel.proj_x, rsp_channel.proj_y, rsp_channel.proj_status);
                  failure_count++;
               end
               if (want.status == STATUS_DEPTH_ZERO) depth_zero_count++;
               if (want.status == STATUS_SATURATED) saturated_count++;
               checked_count++;
            end
         end
         if (req_channel.valid && req_channel.ready)
            expected_points.push_back(project_point(req_channel.point_x, req_channel.point_y,
                                                    req_channel.point_z));
         if (csr_wr_en) begin
            case (csr_index)
               CSR_VIEW_ROW_X:   view_rows[0] = csr_data[ROW_WIDTH-1:0];
               CSR_VIEW_ROW_Y:   view_rows[1] = csr_data[ROW_WIDTH-1:0];
               CSR_VIEW_ROW_Z:   view_rows[2] = csr_data[ROW_WIDTH-1:0];
               CSR_OFFSET_XY:    eye_offset_xy = csr_data[OFFSET_XY_WIDTH-1:0];
               CSR_OFFSET_DEPTH: eye_offset_depth = csr_data[COORD_WIDTH-1:0];
               CSR_FOCAL_SCALE:  focal_scale = csr_data[FOCAL_WIDTH-1:0];
               default: ;
            endcase
         end
      end
      points_in_flight <= expected_points.size();
   end

endmodule

### sim/tb_perspective_point_projection.sv
// Top of the perspective point projection testbench: clock, reset, stimulus and verdict.
module tb_perspective_point_projection;
   timeunit 1ns;
   timeprecision 1ps;
   import ppp_pkg::*;

   localparam int POINTS_PER_PHASE = 128;
   localparam int RANDOM_PHASES    = 9;
   localparam int HOLD_PHASE       = 4;
   localparam int HOLD_CYCLES      = 300;

   typedef logic [COEF_WIDTH-1:0]     coef_type;
   typedef logic [CSR_DATA_WIDTH-1:0] csr_word_type;

   localparam coef_type  COEF_ONE      = coef_type'(1 << COEF_FRAC);
   localparam coef_type  COEF_HALF     = coef_type'(1 << (COEF_FRAC - 1));
   localparam coef_type  COEF_HALF_NEG = coef_type'(-(1 << (COEF_FRAC - 1)));
   localparam coef_type  COEF_MAX      = {1'b0, {(COEF_WIDTH-1){1'b1}}};
   localparam coef_type  COEF_MIN      = {1'b1, {(COEF_WIDTH-1){1'b0}}};
   localparam coord_type COORD_MAX     = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam coord_type COORD_MIN     = {1'b1, {(COORD_WIDTH-1){1'b0}}};
   localparam logic [FOCAL_WIDTH-1:0] FOCAL_ONE = FOCAL_WIDTH'(1) << FOCAL_FRAC;

   // Indexes past the register list; writes there must leave every register alone.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_LOW  = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_HIGH = 3'd7;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;
   typedef enum int {COEF_RANDOM, COEF_NEAR_ONE, COEF_SMALL, COEF_EXTREME} coef_kind_type;

   logic                       clock;
   logic                       reset;
   logic                       csr_wr_en;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   csr_word_type               csr_data;

   int        send_idle_pct;
   int        stall_pct;
   bit        hold_armed;
   bit        holding;
   int        settings_count;
   bit        depth_identity;
   coord_type depth_offset;

   int points_in_flight;
   int failure_count;
   int checked_count;
   int depth_zero_count;
   int saturated_count;

   ppp_req_if req_ch ();
   ppp_rsp_if rsp_ch ();

   perspective_point_projection dut (
      .clock       (clock),
      .reset       (reset),
      .req_channel (req_ch),
      .rsp_channel (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   ppp_projection_checker projection_checker (
      .clock            (clock),
      .reset            (reset),
      .req_channel      (req_ch),
      .rsp_channel      (rsp_ch),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .points_in_flight (points_in_flight),
      .failure_count    (failure_count),
      .checked_count    (checked_count),
      .depth_zero_count (depth_zero_count),
      .saturated_count  (saturated_count)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= !reset && !holding && ($urandom_range(99) >= stall_pct);
      end
   end

   // Long result back-pressure: the pipeline fills and must stall its request side.
   initial begin
      holding = 1'b0;
      wait (hold_armed);
      @(posedge clock);
      holding <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      holding <= 1'b0;
   end

   function automatic logic [ROW_WIDTH-1:0] pack_row(input coef_type cx, input coef_type cy,
                                                     input coef_type cz);
      return {cz, cy, cx};
   endfunction

   function automatic coef_type random_coef(input coef_kind_type kind);
      int v;
      case (kind)
         COEF_RANDOM: return coef_type'($urandom);
         COEF_NEAR_ONE: begin
            v = int'($urandom_range(8192)) - 4096 + (1 << COEF_FRAC);
            if ($urandom_range(1)) v = -v;
            return coef_type'(v);
         end
         COEF_SMALL: return coef_type'(int'($urandom_range(8192)) - 4096);
         default: return $urandom_range(1) ? COEF_MAX : COEF_MIN;
      endcase
   endfunction

   function automatic coord_type random_coord();
      case ($urandom_range(9))
         0, 1, 2, 3, 4: return coord_type'($urandom);
         5, 6:          return coord_type'(int'($urandom_range(2048)) - 1024);
         7:             return $urandom_range(1) ? COORD_MAX : COORD_MIN;
         default:       return '0;
      endcase
   endfunction

   task automatic set_idle(input idle_mode_type mode);
      send_idle_pct = (mode == IDLE_SENDER) ? 55 : (mode == IDLE_BOTH) ? 8 : 0;
      stall_pct <= (mode == IDLE_RECEIVER) ? 55 : (mode == IDLE_BOTH) ? 8 : 0;
   endtask

   task automatic send_point(input coord_type x, input coord_type y, input coord_type z);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.point_x <= x;
      req_ch.point_y <= y;
      req_ch.point_z <= z;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic send_random_point();
      coord_type x;
      coord_type y;
      coord_type z;
      x = random_coord();
      y = random_coord();
      z = random_coord();
      // With a plain depth row the depth can be cancelled exactly by its offset.
      if (depth_identity && $urandom_range(15) == 0) z = -depth_offset;
      send_point(x, y, z);
   endtask

   task automatic wait_for_drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (points_in_flight != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] index,
                                 input csr_word_type value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
   endtask

   task automatic program_view(input csr_word_type row_x, input csr_word_type row_y,
                               input csr_word_type row_z, input csr_word_type offset_xy,
                               input csr_word_type offset_depth, input csr_word_type focal);
      write_register(CSR_VIEW_ROW_X, row_x);
      write_register(CSR_VIEW_ROW_Y, row_y);
      write_register(CSR_VIEW_ROW_Z, row_z);
      write_register(CSR_OFFSET_XY, offset_xy);
      write_register(CSR_OFFSET_DEPTH, offset_depth);
      write_register(CSR_FOCAL_SCALE, focal);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      settings_count++;
   endtask

   initial begin
      csr_word_type focal_word;
      coord_type    offset_x;
      coord_type    offset_y;

      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.point_x = '0;
      req_ch.point_y = '0;
      req_ch.point_z = '0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_data = '0;
      hold_armed = 1'b0;
      settings_count = 1;
      depth_identity = 1'b1;
      depth_offset = '0;
      send_idle_pct = 0;
      stall_pct = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Identity view after reset: the projection is simply x/z and y/z.
      send_point('0, '0, '0);
      send_point(24'sd256, -24'sd256, 24'sd256);
      send_point(COORD_MAX, COORD_MAX, COORD_MAX);
      send_point(COORD_MIN, COORD_MIN, COORD_MIN);
      send_point(COORD_MAX, COORD_MIN, 24'sd1);
      send_point(COORD_MIN, COORD_MAX, 24'sd1);
      send_point(-24'sd1, -24'sd1, -24'sd1);
      send_point(24'sd512, 24'sd768, -24'sd256);
      send_point(24'sd1, '0, COORD_MAX);
      send_point(-24'sd1, '0, COORD_MAX);
      send_point(24'h555555, 24'hAAAAAA, 24'h2AAAAA);
      send_point(24'sd100, 24'sd200, 24'sd3);

      // Largest coefficients, offsets and focal scale.
      wait_for_drain();
      program_view(pack_row(COEF_MAX, COEF_MAX, COEF_MAX), pack_row(COEF_MAX, COEF_MAX, COEF_MAX),
                   pack_row(COEF_MAX, COEF_MAX, COEF_MAX),
                   csr_word_type'({COORD_MAX, COORD_MAX}),
                   csr_word_type'(COORD_MAX), {{(CSR_DATA_WIDTH-FOCAL_WIDTH){1'b0}},
                   {FOCAL_WIDTH{1'b1}}});
      send_point(COORD_MAX, COORD_MAX, COORD_MAX);
      send_point(COORD_MIN, COORD_MIN, COORD_MIN);
      send_point('0, '0, '0);
      send_point(24'sd1, -24'sd1, 24'sd1);

      // Most negative values, zero focal scale and bits above each register width set.
      wait_for_drain();
      program_view(pack_row(COEF_MIN, COEF_MIN, COEF_MIN), pack_row(COEF_MIN, COEF_MIN, COEF_MIN),
                   pack_row(COEF_MIN, COEF_MIN, COEF_MIN),
                   {{(CSR_DATA_WIDTH-OFFSET_XY_WIDTH){1'b1}}, COORD_MIN, COORD_MIN},
                   {{(CSR_DATA_WIDTH-COORD_WIDTH){1'b1}}, COORD_MIN},
                   {{(CSR_DATA_WIDTH-FOCAL_WIDTH){1'b1}}, {FOCAL_WIDTH{1'b0}}});
      write_register(CSR_SPARE_LOW, '1);
      write_register(CSR_SPARE_HIGH, '0);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      send_point(COORD_MAX, COORD_MIN, COORD_MAX);
      send_point(COORD_MIN, COORD_MAX, COORD_MIN);
      send_point('0, '0, '0);
      send_point(24'sd256, 24'sd256, -24'sd256);

      // Half coefficients put eye x and y exactly on rounding ties.
      wait_for_drain();
      program_view(pack_row(COEF_HALF, '0, '0), pack_row('0, COEF_HALF_NEG, '0),
                   pack_row('0, '0, COEF_ONE), '0, '0, csr_word_type'(FOCAL_ONE));
      send_point(24'sd1, 24'sd1, 24'sd256);
      send_point(-24'sd1, -24'sd1, 24'sd256);
      send_point(24'sd3, -24'sd3, 24'sd256);
      send_point(-24'sd3, 24'sd3, -24'sd256);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_for_drain();
         focal_word = csr_word_type'({$urandom, $urandom});
         if ($urandom_range(2) != 0)
            focal_word[FOCAL_WIDTH-1:0] = FOCAL_WIDTH'($urandom_range(32'h40000, 32'h8000));
         if (phase % 2 == 0) begin
            depth_identity = 1'b0;
            program_view(pack_row(random_coef(coef_kind_type'($urandom_range(3))),
                                  random_coef(coef_kind_type'($urandom_range(3))),
                                  random_coef(coef_kind_type'($urandom_range(3)))),
                         pack_row(random_coef(coef_kind_type'($urandom_range(3))),
                                  random_coef(coef_kind_type'($urandom_range(3))),
                                  random_coef(coef_kind_type'($urandom_range(3)))),
                         pack_row(random_coef(coef_kind_type'($urandom_range(3))),
                                  random_coef(coef_kind_type'($urandom_range(3))),
                                  random_coef(coef_kind_type'($urandom_range(3)))),
                         csr_word_type'({$urandom, $urandom}),
                         csr_word_type'({$urandom, $urandom}), focal_word);
         end else begin
            // A camera-like view: near-unit rotation terms and a plain depth row.
            depth_identity = 1'b1;
            depth_offset = coord_type'(int'($urandom_range(131072)) - 65536);
            offset_x = coord_type'(int'($urandom_range(131072)) - 65536);
            offset_y = coord_type'(int'($urandom_range(131072)) - 65536);
            program_view(pack_row(random_coef(COEF_NEAR_ONE), random_coef(COEF_SMALL),
                                  random_coef(COEF_SMALL)),
                         pack_row(random_coef(COEF_SMALL), random_coef(COEF_NEAR_ONE),
                                  random_coef(COEF_SMALL)),
                         pack_row('0, '0, COEF_ONE), csr_word_type'({offset_y, offset_x}),
                         csr_word_type'(depth_offset), focal_word);
         end
         set_idle(idle_mode_type'(phase % 4));
         if (phase == HOLD_PHASE) hold_armed = 1'b1;
         repeat (POINTS_PER_PHASE) send_random_point();
      end

      wait_for_drain();
      repeat (LATENCY + 8) @(posedge clock);
      $display("Checked %0d projected points under %0d view settings, four pacing modes",
               checked_count, settings_count);
      $display("and one long result stall; %0d had zero depth and %0d were clamped.",
               depth_zero_count, saturated_count);
      if (failure_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
